[design/rti_pkg.sv]
`default_nettype none

package rti_pkg;

  // default component width, Q10.10 at 21 bits
  localparam int COORD_BITS_DEF = 21;
  // width of one packed vector field on the request
  localparam int FIELD_BITS = 63;
  // threshold register
  localparam int EPS_BITS = 40;
  localparam logic [EPS_BITS-1:0] EPS_RESET = EPS_BITS'(1);

  typedef logic [FIELD_BITS-1:0] vec_field_t;

  typedef struct packed {
    vec_field_t ray_origin;
    vec_field_t ray_direction;
    vec_field_t vertex_a;
    vec_field_t vertex_b;
    vec_field_t vertex_c;
  } req_t;

  typedef enum logic [2:0] {
    OC_HIT      = 3'd0,
    OC_PARALLEL = 3'd1,
    OC_U_OUT    = 3'd2,
    OC_V_OUT    = 3'd3,
    OC_BEHIND   = 3'd4
  } outcome_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] outcome;
  } rsp_t;

endpackage

`default_nettype wire

[design/rti_skid.sv]
`default_nettype none

module rti_skid
  import rti_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  req_t      in_data,
  output logic      out_valid,
  output req_t      out_data,
  input  wire logic adv
);

  logic skid_valid;
  req_t skid_data;

  // ready comes straight from a register
  assign in_ready  = ~skid_valid;
  assign out_valid = skid_valid | in_valid;
  assign out_data  = skid_valid ? skid_data : in_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (adv) begin
        skid_valid <= 1'b0;
      end
    end else if (in_valid && !adv) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid && in_valid && !adv) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire

[design/rti_front.sv]
`default_nettype none

module rti_front
  import rti_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      adv,
  input  wire logic                      in_valid,
  input  req_t                           req,
  output logic                           out_valid,
  output logic signed [COORD_BITS:0]     d    [3],
  output logic signed [COORD_BITS:0]     e1   [3],
  output logic signed [COORD_BITS:0]     e2   [3],
  output logic signed [COORD_BITS:0]     s    [3],
  output logic signed [2*COORD_BITS+2:0] p    [3],
  output logic signed [2*COORD_BITS+2:0] q    [3]
);

  localparam int EW = COORD_BITS + 1;   // edge width
  localparam int PW = 2 * EW;           // product width
  localparam int CW = PW + 1;           // cross product width

  logic signed [COORD_BITS-1:0] o_in [3], d_in [3], a_in [3], b_in [3], c_in [3];

  // stage 1: edges and origin offset
  logic                 v1;
  logic signed [EW-1:0] d1 [3], e1_1 [3], e2_1 [3], s1 [3];
  // stage 2: cross product terms
  logic                 v2;
  logic signed [EW-1:0] d2 [3], e1_2 [3], e2_2 [3], s2 [3];
  logic signed [PW-1:0] pa [3], pb [3], qa [3], qb [3];
  // stage 3: cross products
  logic                 v3;
  logic signed [EW-1:0] d3 [3], e1_3 [3], e2_3 [3], s3 [3];
  logic signed [CW-1:0] p3 [3], q3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_in[i] = $signed(req.ray_origin[i*COORD_BITS +: COORD_BITS]);
      d_in[i] = $signed(req.ray_direction[i*COORD_BITS +: COORD_BITS]);
      a_in[i] = $signed(req.vertex_a[i*COORD_BITS +: COORD_BITS]);
      b_in[i] = $signed(req.vertex_b[i*COORD_BITS +: COORD_BITS]);
      c_in[i] = $signed(req.vertex_c[i*COORD_BITS +: COORD_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d1[i]   <= EW'(d_in[i]);
        e1_1[i] <= EW'(b_in[i]) - EW'(a_in[i]);
        e2_1[i] <= EW'(c_in[i]) - EW'(a_in[i]);
        s1[i]   <= EW'(o_in[i]) - EW'(a_in[i]);
      end

      // p = d x e2, q = s x e1
      pa[0] <= d1[1] * e2_1[2];
      pb[0] <= d1[2] * e2_1[1];
      pa[1] <= d1[2] * e2_1[0];
      pb[1] <= d1[0] * e2_1[2];
      pa[2] <= d1[0] * e2_1[1];
      pb[2] <= d1[1] * e2_1[0];
      qa[0] <= s1[1] * e1_1[2];
      qb[0] <= s1[2] * e1_1[1];
      qa[1] <= s1[2] * e1_1[0];
      qb[1] <= s1[0] * e1_1[2];
      qa[2] <= s1[0] * e1_1[1];
      qb[2] <= s1[1] * e1_1[0];

      for (int i = 0; i < 3; i++) begin
        d2[i]   <= d1[i];
        e1_2[i] <= e1_1[i];
        e2_2[i] <= e2_1[i];
        s2[i]   <= s1[i];
        p3[i]   <= CW'(pa[i]) - CW'(pb[i]);
        q3[i]   <= CW'(qa[i]) - CW'(qb[i]);
        d3[i]   <= d2[i];
        e1_3[i] <= e1_2[i];
        e2_3[i] <= e2_2[i];
        s3[i]   <= s2[i];
      end
    end
  end

  assign out_valid = v3;
  assign d  = d3;
  assign e1 = e1_3;
  assign e2 = e2_3;
  assign s  = s3;
  assign p  = p3;
  assign q  = q3;

endmodule

`default_nettype wire

[design/rti_dot.sv]
`default_nettype none

module rti_dot
  import rti_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      adv,
  input  wire logic                      in_valid,
  input  wire logic signed [COORD_BITS:0]     d  [3],
  input  wire logic signed [COORD_BITS:0]     e1 [3],
  input  wire logic signed [COORD_BITS:0]     e2 [3],
  input  wire logic signed [COORD_BITS:0]     s  [3],
  input  wire logic signed [2*COORD_BITS+2:0] p  [3],
  input  wire logic signed [2*COORD_BITS+2:0] q  [3],
  output logic                           out_valid,
  output logic signed [3*COORD_BITS+5:0] det,
  output logic signed [3*COORD_BITS+5:0] u_num,
  output logic signed [3*COORD_BITS+5:0] v_num,
  output logic signed [3*COORD_BITS+5:0] t_num
);

  localparam int MW = 3 * COORD_BITS + 4;   // one dot product term
  localparam int SW = MW + 2;               // sum of three terms

  // stage 4: dot product terms
  logic                 v4;
  logic signed [MW-1:0] det_m [3], u_m [3], v_m [3], t_m [3];
  // stage 5: sums
  logic                 v5;
  logic signed [SW-1:0] det5, u5, vv5, t5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v4 <= in_valid;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        det_m[i] <= e1[i] * p[i];
        u_m[i]   <= s[i] * p[i];
        v_m[i]   <= d[i] * q[i];
        t_m[i]   <= e2[i] * q[i];
      end
      det5 <= SW'(det_m[0]) + SW'(det_m[1]) + SW'(det_m[2]);
      u5   <= SW'(u_m[0]) + SW'(u_m[1]) + SW'(u_m[2]);
      vv5  <= SW'(v_m[0]) + SW'(v_m[1]) + SW'(v_m[2]);
      t5   <= SW'(t_m[0]) + SW'(t_m[1]) + SW'(t_m[2]);
    end
  end

  assign out_valid = v5;
  assign det   = det5;
  assign u_num = u5;
  assign v_num = vv5;
  assign t_num = t5;

endmodule

`default_nettype wire

[design/rti_decide.sv]
`default_nettype none

module rti_decide
  import rti_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           adv,
  input  wire logic                           in_valid,
  input  wire logic signed [3*COORD_BITS+5:0] det,
  input  wire logic signed [3*COORD_BITS+5:0] u_num,
  input  wire logic signed [3*COORD_BITS+5:0] v_num,
  input  wire logic signed [3*COORD_BITS+5:0] t_num,
  input  wire logic [EPS_BITS-1:0]            det_epsilon,
  output logic                                out_valid,
  output rsp_t                                rsp
);

  localparam int SW  = 3 * COORD_BITS + 6;
  localparam int XW  = SW + 2;                            // room for negation and u + v
  localparam int CMW = (XW > EPS_BITS) ? XW : EPS_BITS;   // threshold compare width

  logic signed [XW-1:0] det_x, u_x, v_x, t_x;
  logic                 det_neg;

  // stage 6: sign-corrected numerators and |det|
  logic                 v6;
  logic signed [XW-1:0] mag6, u6, vv6, t6;

  // stage 7: decisions, doubles as the output register
  logic                 v7;
  rsp_t                 rsp7;

  logic signed [XW-1:0] uv_sum;
  logic [CMW-1:0]       mag_cmp;
  logic [CMW-1:0]       eps_cmp;
  outcome_t             oc;

  assign det_x   = XW'(det);
  assign u_x     = XW'(u_num);
  assign v_x     = XW'(v_num);
  assign t_x     = XW'(t_num);
  assign det_neg = det[SW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (adv) begin
      v6 <= in_valid;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag6 <= det_neg ? -det_x : det_x;
      u6   <= det_neg ? -u_x : u_x;
      vv6  <= det_neg ? -v_x : v_x;
      t6   <= det_neg ? -t_x : t_x;
    end
  end

  // first failing test wins: parallel, u, v, t
  always_comb begin
    uv_sum  = u6 + vv6;
    mag_cmp = CMW'($unsigned(mag6));
    eps_cmp = CMW'(det_epsilon);
    if (mag6 == '0 || mag_cmp < eps_cmp) begin
      oc = OC_PARALLEL;
    end else if (u6[XW-1] || u6 > mag6) begin
      oc = OC_U_OUT;
    end else if (vv6[XW-1] || uv_sum > mag6) begin
      oc = OC_V_OUT;
    end else if (!t6[XW-1] && t6 != '0) begin
      oc = OC_HIT;
    end else begin
      oc = OC_BEHIND;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp7.hit     <= (oc == OC_HIT);
      rsp7.outcome <= oc;
    end
  end

  assign out_valid = v7;
  assign rsp       = rsp7;

endmodule

`default_nettype wire

[design/ray_triangle_intersection_top.sv]
`default_nettype none

// ray/triangle intersection (moller-trumbore, division free). each request
// carries a ray origin and direction plus three triangle vertices, every
// vector packed as three signed COORD_BITS-bit components (x in the low
// bits, then y, then z; Q10.10 at 21 bits, higher field bits ignored). the
// response gives hit and an outcome code: hit, parallel (|det| is zero or
// below det_epsilon), u outside, v outside (v < 0 or u + v > 1), or hit at or
// behind the origin, checked in that order. u, v and t are never divided
// out; their numerators are compared against |det| after sign correction.
// det_epsilon is in det units (lsb 2^-30 at the default width), resets to 1
// and should only be written while no request is in flight. the datapath is
// a seven-stage pipeline that takes one request every cycle while the
// response side is not stalled; an accepted request is registered into
// stage 1 and moves through the stages to the response register. the depth
// is set by the multiplier stages (cross products, then dot products). a
// stall on the response side freezes the whole pipeline, and a one-entry
// skid buffer on the request side keeps req_ready driven from a register.
module ray_triangle_intersection_top
  import rti_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // request channel
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  req_t                     req,
  // response channel
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output rsp_t                     rsp,
  // threshold register
  input  wire logic                cfg_we,
  input  wire logic [EPS_BITS-1:0] cfg_data
);

  localparam int EW = COORD_BITS + 1;
  localparam int CW = 2 * EW + 1;
  localparam int SW = 3 * COORD_BITS + 6;

  logic [EPS_BITS-1:0] det_epsilon;

  // the whole pipeline moves together unless the output register is held
  logic adv;

  logic front_in_valid;
  req_t front_req;

  logic                 front_valid;
  logic signed [EW-1:0] d [3], e1 [3], e2 [3], s [3];
  logic signed [CW-1:0] p [3], q [3];

  logic                 dot_valid;
  logic signed [SW-1:0] det, u_num, v_num, t_num;

  assign adv = ~rsp_valid | rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_epsilon <= EPS_RESET;
    end else if (cfg_we) begin
      det_epsilon <= cfg_data;
    end
  end

  // request skid buffer
  rti_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_ready  (req_ready),
    .in_data   (req),
    .out_valid (front_in_valid),
    .out_data  (front_req),
    .adv       (adv)
  );

  // stages 1-3: edges, origin offset, p = dir x e2 and q = s x e1
  rti_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (front_in_valid),
    .req       (front_req),
    .out_valid (front_valid),
    .d         (d),
    .e1        (e1),
    .e2        (e2),
    .s         (s),
    .p         (p),
    .q         (q)
  );

  // stages 4-5: det, u, v and t numerators
  rti_dot #(
    .COORD_BITS (COORD_BITS)
  ) u_dot (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (front_valid),
    .d         (d),
    .e1        (e1),
    .e2        (e2),
    .s         (s),
    .p         (p),
    .q         (q),
    .out_valid (dot_valid),
    .det       (det),
    .u_num     (u_num),
    .v_num     (v_num),
    .t_num     (t_num)
  );

  // stages 6-7: sign correction, ordered tests, response register
  rti_decide #(
    .COORD_BITS (COORD_BITS)
  ) u_decide (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (dot_valid),
    .det         (det),
    .u_num       (u_num),
    .v_num       (v_num),
    .t_num       (t_num),
    .det_epsilon (det_epsilon),
    .out_valid   (rsp_valid),
    .rsp         (rsp)
  );

endmodule

`default_nettype wire

[tb/rti_outcome_checker.sv]
`timescale 1ns / 1ps

module rti_outcome_checker
  import rti_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  input  wire logic                req_ready,
  input  req_t                     req,
  input  wire logic                rsp_valid,
  input  wire logic                rsp_ready,
  input  rsp_t                     rsp,
  input  wire logic                cfg_we,
  input  wire logic [EPS_BITS-1:0] cfg_data,
  output int                       outcome_errors,
  output int                       requests_in_flight
);

  // exact intermediates, far wider than any dot product can grow
  typedef logic signed [127:0] wide_t;
  typedef struct packed {
    logic signed [127:0] x;
    logic signed [127:0] y;
    logic signed [127:0] z;
  } vec3_t;

  logic [EPS_BITS-1:0] det_threshold = EPS_RESET;
  outcome_t expected_outcomes[$];

  function automatic vec3_t unpack_vec(input vec_field_t f);
    vec3_t v;
    v.x = 128'($signed(f[COORD_BITS-1:0]));
    v.y = 128'($signed(f[2*COORD_BITS-1:COORD_BITS]));
    v.z = 128'($signed(f[3*COORD_BITS-1:2*COORD_BITS]));
    return v;
  endfunction

  function automatic vec3_t sub3(input vec3_t a, input vec3_t b);
    vec3_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic vec3_t cross3(input vec3_t a, input vec3_t b);
    vec3_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  function automatic wide_t dot3(input vec3_t a, input vec3_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  // division-free moller-trumbore: numerators against |det|, sign corrected
  function automatic outcome_t predict_outcome(input req_t r,
                                               input logic [EPS_BITS-1:0] threshold);
    vec3_t org, dir, va, e1, e2, s, p, q;
    wide_t det, mag, num_u, num_v, num_t, eps_w;
    logic flip;
    org = unpack_vec(r.ray_origin);
    dir = unpack_vec(r.ray_direction);
    va  = unpack_vec(r.vertex_a);
    e1  = sub3(unpack_vec(r.vertex_b), va);
    e2  = sub3(unpack_vec(r.vertex_c), va);
    s   = sub3(org, va);
    eps_w = 128'(threshold);
    p   = cross3(dir, e2);
    det = dot3(e1, p);
    flip = det < 0;
    mag  = flip ? -det : det;
    if (mag == 0 || mag < eps_w) return OC_PARALLEL;
    num_u = dot3(s, p);
    if (flip) num_u = -num_u;
    if (num_u < 0 || num_u > mag) return OC_U_OUT;
    q = cross3(s, e1);
    num_v = dot3(dir, q);
    if (flip) num_v = -num_v;
    if (num_v < 0 || num_u + num_v > mag) return OC_V_OUT;
    num_t = dot3(e2, q);
    if (flip) num_t = -num_t;
    return (num_t > 0) ? OC_HIT : OC_BEHIND;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      det_threshold = EPS_RESET;
      expected_outcomes.delete();
      outcome_errors = 0;
    end else begin
      if (cfg_we) det_threshold = cfg_data;
      if (rsp_valid && rsp_ready) begin
        if (expected_outcomes.size() == 0) begin
          $error("response with no request pending: hit %0b outcome %0d",
                 rsp.hit, rsp.outcome);
          outcome_errors++;
        end else begin
          want = expected_outcomes.pop_front();
          if (rsp.hit !== (want == OC_HIT)) begin
            $error("hit: expected %0b, got %0b", want == OC_HIT, rsp.hit);
            outcome_errors++;
          end
          if (rsp.outcome !== want) begin
            $error("outcome: expected %0d, got %0d", want, rsp.outcome);
            outcome_errors++;
          end
        end
      end
      if (req_valid && req_ready)
        expected_outcomes.push_back(predict_outcome(req, det_threshold));
    end
    requests_in_flight = expected_outcomes.size();
  end

endmodule

[tb/ray_triangle_intersection_top_tb.sv]
`timescale 1ns / 1ps

module ray_triangle_intersection_top_tb;
  import rti_pkg::*;

  localparam int COORD_BITS        = COORD_BITS_DEF;
  localparam int ONE               = 1024;   // 1.0 in q10.10
  localparam int CMIN              = -(1 << (COORD_BITS - 1));
  localparam int CMAX              = (1 << (COORD_BITS - 1)) - 1;
  localparam int SEGMENTS          = 6;
  localparam int REQS_PER_SEGMENT  = 325;
  localparam int RSP_HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES     = 16;    // pipeline is seven deep, leave margin
  localparam int WATCHDOG_LIMIT    = 5000;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_ready;
  req_t                req       = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  rsp_t                rsp;
  logic                cfg_we    = 1'b0;
  logic [EPS_BITS-1:0] cfg_data  = '0;

  logic hold_rsp      = 1'b0;
  int   send_idle_pct = 6;
  int   recv_idle_pct = 73;
  int   outcome_errors;
  int   requests_in_flight;
  int   idle_cycles   = 0;

  always #4 clk = ~clk;

  ray_triangle_intersection_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // predicts every accepted request and checks responses in order
  rti_outcome_checker #(
    .COORD_BITS (COORD_BITS)
  ) i_outcome_checker (
    .clk                (clk),
    .rst                (rst),
    .req_valid          (req_valid),
    .req_ready          (req_ready),
    .req                (req),
    .rsp_valid          (rsp_valid),
    .rsp_ready          (rsp_ready),
    .rsp                (rsp),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .outcome_errors     (outcome_errors),
    .requests_in_flight (requests_in_flight)
  );

  // response side: random back-pressure, or a solid hold-off when asked
  always @(negedge clk) begin
    rsp_ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
  end

  // give up when neither channel has moved for too long
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ray_triangle_intersection_top_tb failed");
      $finish;
    end
  end

  function automatic int rand_coord(input int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  // x in the low bits, then y, then z
  function automatic vec_field_t pack3(input int x, input int y, input int z);
    return vec_field_t'({z[COORD_BITS-1:0], y[COORD_BITS-1:0], x[COORD_BITS-1:0]});
  endfunction

  // mostly rays aimed near a random triangle, plus in-plane rays, tiny
  // degenerate geometry and raw bit noise
  function automatic req_t random_request();
    int   a [3];
    int   b [3];
    int   c [3];
    int   o [3];
    int   d [3];
    int   lim, kind, w1, w2, k1, k2, i;
    req_t r;
    kind = $urandom_range(99);
    lim  = 1 << $urandom_range(17, 3);
    if (kind >= 65 && kind < 80) lim = 3;
    if (kind >= 80) begin
      r.ray_origin    = vec_field_t'({$urandom, $urandom});
      r.ray_direction = vec_field_t'({$urandom, $urandom});
      r.vertex_a      = vec_field_t'({$urandom, $urandom});
      r.vertex_b      = vec_field_t'({$urandom, $urandom});
      r.vertex_c      = vec_field_t'({$urandom, $urandom});
      return r;
    end
    for (i = 0; i < 3; i++) begin
      a[i] = rand_coord(lim);
      b[i] = rand_coord(lim);
      c[i] = rand_coord(lim);
      o[i] = rand_coord(lim);
      d[i] = rand_coord(lim);
    end
    if (kind < 50) begin
      // barycentric weights in 1/256, a few beyond the triangle on each side
      w1 = int'($urandom_range(300)) - 22;
      w2 = int'($urandom_range(300)) - 22;
      for (i = 0; i < 3; i++)
        d[i] = a[i] + ((b[i] - a[i]) * w1 + (c[i] - a[i]) * w2) / 256 - o[i];
      if ($urandom_range(6) == 0)
        for (i = 0; i < 3; i++) d[i] = -d[i];
    end else if (kind < 65) begin
      // direction inside the triangle's plane: det is exactly zero
      k1 = rand_coord(1);
      k2 = rand_coord(1);
      for (i = 0; i < 3; i++) d[i] = (b[i] - a[i]) * k1 + (c[i] - a[i]) * k2;
    end
    r.ray_origin    = pack3(o[0], o[1], o[2]);
    r.ray_direction = pack3(d[0], d[1], d[2]);
    r.vertex_a      = pack3(a[0], a[1], a[2]);
    r.vertex_b      = pack3(b[0], b[1], b[2]);
    r.vertex_c      = pack3(c[0], c[1], c[2]);
    return r;
  endfunction

  // called at a falling edge; valid stays up after acceptance so that the
  // next request can follow back to back without a glitch
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic send_tri(input vec_field_t o, input vec_field_t d, input vec_field_t a,
                          input vec_field_t b, input vec_field_t c);
    req_t r;
    r.ray_origin    = o;
    r.ray_direction = d;
    r.vertex_a      = a;
    r.vertex_b      = b;
    r.vertex_c      = c;
    send_request(r);
  endtask

  // drop valid and wait until every response is back and the pipe is empty
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (requests_in_flight != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [EPS_BITS-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // unit-lsb triangle: |det| is exactly 1, so the threshold decides
  task automatic send_threshold_probes();
    send_tri(pack3(0, 0, 1), pack3(0, 0, -1), pack3(0, 0, 0),
             pack3(1, 0, 0), pack3(0, 1, 0));
    send_tri('0, '0, '0, '0, '0);
  endtask

  initial begin
    logic [EPS_BITS-1:0] threshold;
    int seg, n;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: unit triangle in z = 0, ray from z = 1 looking down
    send_tri('0, '0, '0, '0, '0);                         // zero det, parallel
    send_tri('1, '1, '1, '1, '1);                         // all components -1
    send_tri(pack3(256, 256, ONE), pack3(0, 0, -ONE), '0,
             pack3(ONE, 0, 0), pack3(0, ONE, 0));          // plain hit
    send_tri(pack3(256, 256, ONE), pack3(0, 0, ONE), '0,
             pack3(ONE, 0, 0), pack3(0, ONE, 0));          // pointing away
    send_tri(pack3(256, 256, 0), pack3(0, 0, -ONE), '0,
             pack3(ONE, 0, 0), pack3(0, ONE, 0));          // origin on the plane
    send_tri(pack3(-256, 256, ONE), pack3(0, 0, -ONE), '0,
             pack3(ONE, 0, 0), pack3(0, ONE, 0));          // u below zero
    send_tri(pack3(256, -256, ONE), pack3(0, 0, -ONE), '0,
             pack3(ONE, 0, 0), pack3(0, ONE, 0));          // v below zero
    send_tri(pack3(768, 768, ONE), pack3(0, 0, -ONE), '0,
             pack3(ONE, 0, 0), pack3(0, ONE, 0));          // u + v above one
    send_tri(pack3(0, 512, ONE), pack3(0, 0, -ONE), '0,
             pack3(ONE, 0, 0), pack3(0, ONE, 0));          // u exactly zero
    send_tri(pack3(ONE, 0, ONE), pack3(0, 0, -ONE), '0,
             pack3(ONE, 0, 0), pack3(0, ONE, 0));          // u exactly one
    send_tri(pack3(512, 512, ONE), pack3(0, 0, -ONE), '0,
             pack3(ONE, 0, 0), pack3(0, ONE, 0));          // u + v exactly one
    send_tri(pack3(256, 256, ONE), pack3(ONE, 0, 0), '0,
             pack3(ONE, 0, 0), pack3(0, ONE, 0));          // ray along the plane
    // flipped winding, negative det
    send_tri(pack3(256, 256, ONE), pack3(0, 0, -ONE), '0,
             pack3(0, ONE, 0), pack3(ONE, 0, 0));
    send_tri(pack3(256, 256, ONE), pack3(0, 0, ONE), '0,
             pack3(0, ONE, 0), pack3(ONE, 0, 0));
    send_tri(pack3(-256, 256, ONE), pack3(0, 0, -ONE), '0,
             pack3(0, ONE, 0), pack3(ONE, 0, 0));
    send_tri(pack3(768, 768, ONE), pack3(0, 0, -ONE), '0,
             pack3(0, ONE, 0), pack3(ONE, 0, 0));
    // full-scale components
    send_tri(pack3(0, 0, CMAX), pack3(0, 0, CMIN), pack3(CMIN, CMIN, CMIN),
             pack3(CMAX, CMIN, CMIN), pack3(CMIN, CMAX, CMIN));
    send_tri(pack3(CMIN, CMIN, CMIN), pack3(CMAX, CMAX, CMAX), pack3(CMAX, 0, 0),
             pack3(0, CMAX, 0), pack3(0, 0, CMAX));
    send_tri(pack3(CMAX, CMAX, CMAX), pack3(CMIN, CMIN, CMIN), pack3(CMAX, CMIN, 0),
             pack3(CMIN, CMAX, 0), pack3(0, 0, CMIN));
    send_threshold_probes();

    // random segments, each under its own threshold, with an idling mix per pair of segments
    for (seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      case (seg)
        0: threshold = '0;
        1: threshold = '1;
        2: threshold = EPS_BITS'({$urandom, $urandom});
        3: threshold = EPS_BITS'(1) << 30;
        4: threshold = EPS_BITS'($urandom_range(1 << 20));
        default: threshold = EPS_RESET;
      endcase
      send_idle_pct = (seg < 2) ? 6 : (seg < 4) ? 73 : 0;
      recv_idle_pct = (seg < 2) ? 73 : (seg < 4) ? 6 : 0;
      write_threshold(threshold);
      if (seg == SEGMENTS - 1) begin
        // long response stall while requests keep coming: pipe fills up
        fork
          begin
            hold_rsp <= 1'b1;
            repeat (RSP_HOLD_CYCLES) @(negedge clk);
            hold_rsp <= 1'b0;
          end
        join_none
      end
      send_threshold_probes();
      for (n = 0; n < REQS_PER_SEGMENT; n++) begin
        // sender pause: let everything drain mid-stream
        if (seg == 2 && n == REQS_PER_SEGMENT / 2) wait_idle();
        send_request(random_request());
      end
    end

    wait_idle();
    if (outcome_errors == 0 && requests_in_flight == 0) begin
      $display("ray_triangle_intersection_top_tb passed");
    end else begin
      $display("ray_triangle_intersection_top_tb failed");
    end
    $finish;
  end

endmodule
